// File: src/nfcss_pkg.sv
// Shared types, constants and helpers for the nearest free cell spiral search block.
package nfcss_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int CFG_W   = 7;
    localparam int CELLS   = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CLR_W   = ADDR_W + 1;
    localparam int CRD_W   = 8;
    localparam int DIST_W  = 7;
    localparam int CNT_W   = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef logic signed [CRD_W-1:0] t_coord;

    typedef struct packed {
        logic             opcode;
        logic [COL_W-1:0] cell_x;
        logic [ROW_W-1:0] cell_y;
        logic             occupied_bit;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] found_x;
        logic [ROW_W-1:0] found_y;
    } t_out_item;

    typedef struct packed {
        logic   emit;
        t_coord cx;
        t_coord cy;
        logic   inb;
        logic   term;
    } t_walk_out;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] x,
                                                    input logic [ROW_W-1:0] y);
        cell_addr = ADDR_W'(x) * ADDR_W'(MAX_ROWS) + ADDR_W'(y);
    endfunction

endpackage

// File: src/nearest_free_cell_spiral_search.sv
// Top level of the nearest free cell spiral search block.
// A write transaction is stored at the edge that accepts it; the input is ready again the next cycle.
// A search checks one cell per cycle along the spiral until it finds a free cell or runs out of grid.
// Only one search runs at a time. Reset: synchronous, active low, then a clearing pass that zeroes
// every cell of the bitmap; no input is accepted until it completes.
module nearest_free_cell_spiral_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nfcss_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nfcss_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [nfcss_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_HOLD   = 2'd2;

    logic [1:0]                       r_state, n_state;
    logic [nfcss_pkg::CFG_W-1:0]      r_grid_w;
    logic [nfcss_pkg::CFG_W-1:0]      r_grid_h;
    logic                             r_clearing;
    logic [nfcss_pkg::CLR_W-1:0]      r_clr_cnt;

    // The occupancy bitmap, one bit per cell, column-major.
    logic                             r_map [nfcss_pkg::CELLS];
    logic                             r_rd_bit;

    // Candidate cell whose memory read is in flight, lined up with r_rd_bit.
    logic                             r_p_valid;
    logic [nfcss_pkg::COL_W-1:0]      r_p_x;
    logic [nfcss_pkg::ROW_W-1:0]      r_p_y;
    logic                             r_p_inb;

    nfcss_pkg::t_out_item             r_res, n_res;
    nfcss_pkg::t_out_item             r_out;
    logic                             r_out_valid;

    logic [nfcss_pkg::CFG_W-1:0]      w_eff;
    logic [nfcss_pkg::CFG_W-1:0]      h_eff;
    logic                             in_acc;
    logic                             start_search;
    logic                             hit;
    logic                             load_out;
    logic                             mem_we;
    logic [nfcss_pkg::ADDR_W-1:0]     mem_wa;
    logic                             mem_wd;
    logic [nfcss_pkg::ADDR_W-1:0]     mem_ra;
    nfcss_pkg::t_walk_out             walk;

    // Register values beyond the storage size saturate to it.
    assign w_eff = (r_grid_w > nfcss_pkg::CFG_W'(nfcss_pkg::MAX_COLUMNS))
                 ? nfcss_pkg::CFG_W'(nfcss_pkg::MAX_COLUMNS) : r_grid_w;
    assign h_eff = (r_grid_h > nfcss_pkg::CFG_W'(nfcss_pkg::MAX_ROWS))
                 ? nfcss_pkg::CFG_W'(nfcss_pkg::MAX_ROWS) : r_grid_h;

    assign o_in_ready   = (r_state == ST_IDLE) && !r_clearing;
    assign o_cfg_ready  = 1'b1;
    assign in_acc       = i_in_valid && o_in_ready;
    assign start_search = in_acc && (i_in_data.opcode == nfcss_pkg::OP_SEARCH);

    // A candidate is a hit when it lies in the grid and its bit reads free.
    assign hit = (r_state == ST_SEARCH) && r_p_valid && r_p_inb && !r_rd_bit;

    nfcss_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_search),
        .i_stop  (hit),
        .i_x     (i_in_data.cell_x),
        .i_y     (i_in_data.cell_y),
        .i_w     (w_eff),
        .i_h     (h_eff),
        .o_walk  (walk)
    );

    // The clearing pass owns the write port until it has swept every cell.
    assign mem_we = r_clearing || (in_acc && (i_in_data.opcode == nfcss_pkg::OP_WRITE));
    assign mem_wa = r_clearing ? r_clr_cnt[nfcss_pkg::ADDR_W-1:0]
                               : nfcss_pkg::cell_addr(i_in_data.cell_x, i_in_data.cell_y);
    assign mem_wd = r_clearing ? 1'b0 : i_in_data.occupied_bit;
    assign mem_ra = nfcss_pkg::cell_addr(walk.cx[nfcss_pkg::COL_W-1:0],
                                         walk.cy[nfcss_pkg::ROW_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        r_rd_bit <= r_map[mem_ra];
    end

    assign load_out = (r_state == ST_HOLD) && (!r_out_valid || i_out_ready);

    // Sequencer: a search finishes on the first free candidate, or when the walker
    // reports that the whole ring lies outside the grid with nothing left in flight.
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (start_search) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_res.found   = 1'b1;
                    n_res.found_x = r_p_x;
                    n_res.found_y = r_p_y;
                    n_state       = ST_HOLD;
                end else if (walk.term) begin
                    n_res   = '0;
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_grid_w    <= nfcss_pkg::CFG_W'(nfcss_pkg::MAX_COLUMNS);
            r_grid_h    <= nfcss_pkg::CFG_W'(nfcss_pkg::MAX_ROWS);
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == nfcss_pkg::CLR_W'(nfcss_pkg::CELLS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    nfcss_pkg::CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                    nfcss_pkg::CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                    default: ;
                endcase
            end
            r_p_valid <= (r_state == ST_SEARCH) && walk.emit && !hit;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_p_x <= walk.cx[nfcss_pkg::COL_W-1:0];
        r_p_y <= walk.cy[nfcss_pkg::ROW_W-1:0];
        r_p_inb <= walk.inb;
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/nfcss_walker.sv
// Ring walker that issues one candidate cell per cycle along the square spiral.
module nfcss_walker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_stop,
    input  logic [nfcss_pkg::COL_W-1:0]         i_x,
    input  logic [nfcss_pkg::ROW_W-1:0]         i_y,
    input  logic [nfcss_pkg::CFG_W-1:0]         i_w,
    input  logic [nfcss_pkg::CFG_W-1:0]         i_h,
    output nfcss_pkg::t_walk_out                o_walk
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RING = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    localparam logic [2:0] SEG_EAST_A = 3'd0;
    localparam logic [2:0] SEG_SOUTH  = 3'd1;
    localparam logic [2:0] SEG_WEST   = 3'd2;
    localparam logic [2:0] SEG_NORTH  = 3'd3;
    localparam logic [2:0] SEG_EAST_B = 3'd4;

    logic [1:0]                        r_state, n_state;
    logic [2:0]                        r_seg, n_seg;
    logic [nfcss_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [nfcss_pkg::DIST_W-1:0]      r_d, n_d;
    logic [nfcss_pkg::COL_W-1:0]       r_x, n_x;
    logic [nfcss_pkg::ROW_W-1:0]       r_y, n_y;
    nfcss_pkg::t_coord                 r_cx, n_cx;
    nfcss_pkg::t_coord                 r_cy, n_cy;

    logic [nfcss_pkg::CRD_W-1:0]       x_plus_d;
    logic [nfcss_pkg::CRD_W-1:0]       y_plus_d;
    logic [nfcss_pkg::CNT_W-1:0]       two_d;
    logic                              ring_out;
    nfcss_pkg::t_coord                 w_s;
    nfcss_pkg::t_coord                 h_s;

    assign x_plus_d = nfcss_pkg::CRD_W'(r_x) + nfcss_pkg::CRD_W'(r_d);
    assign y_plus_d = nfcss_pkg::CRD_W'(r_y) + nfcss_pkg::CRD_W'(r_d);
    assign two_d    = {r_d, 1'b0};
    assign w_s      = nfcss_pkg::CRD_W'(i_w);
    assign h_s      = nfcss_pkg::CRD_W'(i_h);

    // The ring at distance d is wholly outside the grid on all four sides.
    assign ring_out = (r_d > nfcss_pkg::DIST_W'(r_x)) &&
                      (x_plus_d >= nfcss_pkg::CRD_W'(i_w)) &&
                      (r_d > nfcss_pkg::DIST_W'(r_y)) &&
                      (y_plus_d >= nfcss_pkg::CRD_W'(i_h));

    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_x     = r_x;
        n_y     = r_y;
        n_cx    = r_cx;
        n_cy    = r_cy;
        o_walk  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_x     = i_x;
                    n_y     = i_y;
                    n_d     = '0;
                    n_state = S_RING;
                end
            end
            S_RING: begin
                if (ring_out) begin
                    o_walk.term = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    // The first cell of each ring sits straight above the start.
                    n_cx        = nfcss_pkg::CRD_W'(r_x);
                    n_cy        = $signed(y_plus_d);
                    o_walk.emit = 1'b1;
                    if (r_d == '0) begin
                        n_d = r_d + 1'b1;
                    end else begin
                        n_seg   = SEG_EAST_A;
                        n_cnt   = nfcss_pkg::CNT_W'(r_d);
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                case (r_seg)
                    SEG_EAST_A: n_cx = r_cx + 8'sd1;
                    SEG_SOUTH:  n_cy = r_cy - 8'sd1;
                    SEG_WEST:   n_cx = r_cx - 8'sd1;
                    SEG_NORTH:  n_cy = r_cy + 8'sd1;
                    SEG_EAST_B: n_cx = r_cx + 8'sd1;
                    default:    n_cx = r_cx;
                endcase
                o_walk.emit = 1'b1;
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == nfcss_pkg::CNT_W'(1)) begin
                    if ((r_seg == SEG_EAST_B) ||
                        ((r_seg == SEG_NORTH) && (r_d == nfcss_pkg::DIST_W'(1)))) begin
                        n_d     = r_d + 1'b1;
                        n_state = S_RING;
                    end else begin
                        n_seg = r_seg + 1'b1;
                        n_cnt = (r_seg == SEG_NORTH) ? nfcss_pkg::CNT_W'(r_d) - 1'b1
                                                     : two_d;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        o_walk.cx  = n_cx;
        o_walk.cy  = n_cy;
        o_walk.inb = (n_cx >= 0) && (n_cx < w_s) && (n_cy >= 0) && (n_cy < h_s);

        if (i_stop) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_seg <= n_seg;
        r_cnt <= n_cnt;
        r_d   <= n_d;
        r_x   <= n_x;
        r_y   <= n_y;
        r_cx  <= n_cx;
        r_cy  <= n_cy;
    end

endmodule

// File: src/nfcss_checker.sv
// Port-level checker for the nearest free cell spiral search, bound to the top level.
module nfcss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input nfcss_pkg::t_in_item           i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input nfcss_pkg::t_out_item          o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction changed while stalled");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.found_x == '0 && o_out_data.found_y == '0)
        else $error("empty result carries a nonzero cell");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.opcode == nfcss_pkg::OP_SEARCH |=> !o_in_ready)
        else $error("ready while a search is in progress");

    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.opcode == nfcss_pkg::OP_WRITE |=> o_in_ready)
        else $error("write transaction did not complete in one cycle");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("activity right after reset");

endmodule

bind nearest_free_cell_spiral_search nfcss_checker u_nfcss_checker (.*);
